// ===== rtl/core/ctn_pkg.sv =====
// Package for the Cyrillic text normalizer.
// Holds the byte constants and the result word type used by the top level.
// Depends on nothing.
package ctn_pkg;

    localparam logic [7:0] BYTE_SPACE   = 8'h20;
    localparam logic [7:0] BYTE_TAB     = 8'h09;
    localparam logic [7:0] BYTE_CR      = 8'h0D;
    localparam logic [7:0] BYTE_LF      = 8'h0A;
    localparam logic [7:0] BYTE_UPPER_A = 8'h41;
    localparam logic [7:0] BYTE_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFSET  = 8'h20;
    localparam logic [7:0] LEAD_D0      = 8'hD0;
    localparam logic [7:0] LEAD_D1      = 8'hD1;
    localparam logic [7:0] YO_UPPER     = 8'h81;
    localparam logic [7:0] YO_LOWER     = 8'h91;
    localparam logic [7:0] YE_LOWER     = 8'hB5;
    localparam logic [7:0] CAP_LO_FIRST = 8'h90;
    localparam logic [7:0] CAP_LO_LAST  = 8'h9F;
    localparam logic [7:0] CAP_HI_FIRST = 8'hA0;
    localparam logic [7:0] CAP_HI_LAST  = 8'hAF;

    // One result word as it sits in the output buffer.
    typedef struct packed {
        logic [7:0] data;
        logic       has_byte;
        logic       run_last;
        logic       text_end;
    } res_t;

endpackage

// ===== rtl/core/ctn_if.sv =====
// Stream interfaces of the Cyrillic text normalizer: raw bytes in, normalized words out.
// Each carries valid, ready and the payload; depends on nothing.
interface ctn_raw_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

interface ctn_norm_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       out_valid;
    logic       run_last;
    logic       text_end;

    modport source (output valid, output out_byte, output out_valid, output run_last,
                    output text_end, input ready);
    modport sink   (input valid, input out_byte, input out_valid, input run_last,
                    input text_end, output ready);
endinterface

// ===== rtl/core/cyrillic_text_normalizer_top.sv =====
// Cyrillic text normalizer, top level. Uses ctn_pkg and the interfaces in ctn_if.sv.
// Folds case and whitespace of UTF-8 text, one byte per cycle while the output has room.

// The block takes one byte of UTF-8 text per cycle and gives the normalized text on the
// output channel: ASCII and Cyrillic capitals are lowercased, both Yo forms become D0 B5,
// and whitespace is trimmed at the ends and collapsed to one space inside. A byte is
// decided in the cycle it is accepted and its results (zero, one or two words) land in a
// two-entry output buffer, so results appear in the next cycle. The input is taken
// every cycle as long as each byte yields at most one word and the output is drained;
// a byte that yields two words holds the next byte back until one has drained, as the
// buffer drains one word per cycle. The final byte of a text always yields at least one
// word; the last carries text_end, and if nothing is left to send it has out_valid cleared.
module cyrillic_text_normalizer_top (
    input  logic           clk,
    input  logic           rst_n,
    ctn_raw_if.sink        raw,
    ctn_norm_if.source     norm
);

    typedef enum logic [1:0] {
        HELD_NONE = 2'd0,
        HELD_D0   = 2'd1,
        HELD_D1   = 2'd2
    } held_t;

    held_t            held_reg, held_next;
    logic             space_reg, space_next;
    logic             seen_reg, seen_next;
    logic [1:0]       cnt_reg, cnt_next;
    ctn_pkg::res_t    slot0_reg, slot0_next;
    ctn_pkg::res_t    slot1_reg, slot1_next;

    logic             accept;
    logic             drain;
    logic [1:0]       n;
    logic [1:0]       n_res;
    logic [7:0]       ob [0:1];
    logic             fresh_en;
    logic             is_ws;
    logic             empty_end;
    logic [7:0]       x;
    ctn_pkg::res_t    r0, r1;

    assign x      = raw.in_byte;
    assign drain  = norm.valid && norm.ready;
    assign raw.ready = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && norm.ready);
    assign accept = raw.valid && raw.ready;

    assign is_ws = (x == ctn_pkg::BYTE_SPACE) || (x == ctn_pkg::BYTE_TAB) ||
                   (x == ctn_pkg::BYTE_CR) || (x == ctn_pkg::BYTE_LF);

    // Decide the words caused by the incoming byte and the state it leaves.
    always_comb
    begin
        n          = 2'd0;
        ob[0]      = 8'h00;
        ob[1]      = 8'h00;
        fresh_en   = 1'b1;
        held_next  = HELD_NONE;
        space_next = space_reg;
        seen_next  = seen_reg;

        unique case (held_reg)
            HELD_D0:
            begin
                if (x == ctn_pkg::YO_UPPER)
                begin
                    ob[0] = ctn_pkg::LEAD_D0;
                    ob[1] = ctn_pkg::YE_LOWER;
                    n = 2'd2;
                    fresh_en = 1'b0;
                end
                else if (x >= ctn_pkg::CAP_LO_FIRST && x <= ctn_pkg::CAP_LO_LAST)
                begin
                    ob[0] = ctn_pkg::LEAD_D0;
                    ob[1] = x + ctn_pkg::CASE_OFFSET;
                    n = 2'd2;
                    fresh_en = 1'b0;
                end
                else if (x >= ctn_pkg::CAP_HI_FIRST && x <= ctn_pkg::CAP_HI_LAST)
                begin
                    ob[0] = ctn_pkg::LEAD_D1;
                    ob[1] = x - ctn_pkg::CASE_OFFSET;
                    n = 2'd2;
                    fresh_en = 1'b0;
                end
                else
                begin
                    ob[0] = ctn_pkg::LEAD_D0;
                    n = 2'd1;
                end
            end
            HELD_D1:
            begin
                if (x == ctn_pkg::YO_LOWER)
                begin
                    ob[0] = ctn_pkg::LEAD_D0;
                    ob[1] = ctn_pkg::YE_LOWER;
                    n = 2'd2;
                    fresh_en = 1'b0;
                end
                else
                begin
                    ob[0] = ctn_pkg::LEAD_D1;
                    n = 2'd1;
                end
            end
            default:
            begin
            end
        endcase

        // A byte that is not the second half of a pair is handled on its own.
        if (fresh_en)
        begin
            if (is_ws)
            begin
                if (seen_reg)
                    space_next = 1'b1;
            end
            else
            begin
                if (space_reg && seen_reg)
                begin
                    ob[n[0]] = ctn_pkg::BYTE_SPACE;
                    n = n + 2'd1;
                end
                space_next = 1'b0;
                seen_next  = 1'b1;
                if (x == ctn_pkg::LEAD_D0)
                    held_next = HELD_D0;
                else if (x == ctn_pkg::LEAD_D1)
                    held_next = HELD_D1;
                else
                begin
                    if (x >= ctn_pkg::BYTE_UPPER_A && x <= ctn_pkg::BYTE_UPPER_Z)
                        ob[n[0]] = x + ctn_pkg::CASE_OFFSET;
                    else
                        ob[n[0]] = x;
                    n = n + 2'd1;
                end
            end
        end

        empty_end = 1'b0;
        if (raw.in_last)
        begin
            // A lead byte left alone at the end passes through unchanged.
            if (held_next == HELD_D0)
            begin
                ob[n[0]] = ctn_pkg::LEAD_D0;
                n = n + 2'd1;
            end
            else if (held_next == HELD_D1)
            begin
                ob[n[0]] = ctn_pkg::LEAD_D1;
                n = n + 2'd1;
            end
            empty_end  = (n == 2'd0);
            held_next  = HELD_NONE;
            space_next = 1'b0;
            seen_next  = 1'b0;
        end

        n_res = empty_end ? 2'd1 : n;

        r0.data     = ob[0];
        r0.has_byte = !empty_end;
        r0.run_last = (n_res == 2'd1);
        r0.text_end = raw.in_last && (n_res == 2'd1);
        r1.data     = ob[1];
        r1.has_byte = 1'b1;
        r1.run_last = 1'b1;
        r1.text_end = raw.in_last;
    end

    // Output buffer: a new byte is only taken when its words all fit.
    always_comb
    begin
        cnt_next   = cnt_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (accept)
        begin
            cnt_next   = n_res;
            slot0_next = r0;
            slot1_next = r1;
        end
        else if (drain)
        begin
            cnt_next   = cnt_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_reg  <= HELD_NONE;
            space_reg <= 1'b0;
            seen_reg  <= 1'b0;
            cnt_reg   <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (accept)
            begin
                held_reg  <= held_next;
                space_reg <= space_next;
                seen_reg  <= seen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign norm.valid     = (cnt_reg != 2'd0);
    assign norm.out_byte  = slot0_reg.has_byte ? slot0_reg.data : 8'h00;
    assign norm.out_valid = slot0_reg.has_byte;
    assign norm.run_last  = slot0_reg.run_last;
    assign norm.text_end  = slot0_reg.text_end;

`ifndef ASSERT_OFF
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("output buffer count out of range");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> (!slot0_reg.run_last && slot1_reg.run_last))
        else $error("two buffered words do not form one run");

    a_empty_marker: assert property (@(posedge clk) disable iff (!rst_n)
        (norm.valid && !norm.out_valid) |-> (norm.text_end && norm.run_last))
        else $error("empty word outside a text end");

    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && raw.in_last) |=> (held_reg == HELD_NONE && !seen_reg && !space_reg))
        else $error("state not cleared after text end");
`endif

endmodule
